FILE: sv/assert_macros.svh
// Assertion macros shared by the force accumulator RTL.
// Each macro expands to a concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: sv/tefa_pkg.sv
// Shared types and constants of the t-SNE edge force accumulator.
// No dependencies.
package tefa_pkg;
  localparam int unsigned DimsDefault = 2;
  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned MagW   = 24;
  localparam int unsigned DqW    = 50;
  localparam int unsigned AffW   = 32;
  localparam int unsigned IdxW   = 20;
  localparam int unsigned ForceW = 48;
  localparam int unsigned DivW   = 64;
  localparam int unsigned QueueDepth = 2;

  // Classified edge handed from front to back.
  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [2:0]        neg;
    logic [MagW-1:0]   mag_x;
    logic [MagW-1:0]   mag_y;
    logic [MagW-1:0]   mag_z;
    logic [DqW-1:0]    dq;
    logic [AffW-1:0]   aff;
    logic              last;
  } edge_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_ACC, ST_OUT
  } back_state_e;
endpackage

FILE: sv/tefa_front.sv
// Front end: accepts edges, forms differences and squared distance.
// Depends on tefa_pkg. Feeds a two-entry queue toward the back end.
`include "assert_macros.svh"
module tefa_front import tefa_pkg::*; #(
  parameter int unsigned Dims = DimsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IdxW-1:0]          point_index_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic signed [CoordW-1:0] neighbor_x_i,
  input  logic signed [CoordW-1:0] neighbor_y_i,
  input  logic signed [CoordW-1:0] neighbor_z_i,
  input  logic [AffW-1:0]          affinity_i,
  input  logic                     last_in_row_i,
  output logic                     q_valid_o,
  input  logic                     q_pop_i,
  output edge_t                    q_head_o
);
  // stage 1: differences and magnitudes
  logic              s1_valid_q;
  edge_t             s1_q, s1_d;
  logic signed [DiffW-1:0] dx, dy, dz;
  logic [MagW-1:0]   ax, ay, az;
  // stage 2 squares: registered before the sum
  logic              s2_valid_q;
  edge_t             s2_q;
  logic [2*MagW-1:0] sq_x_q, sq_y_q, sq_z_q;
  // queue
  edge_t             mem_q [QueueDepth];
  edge_t             push_e;
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              push, s1_adv, s2_adv, acc_in;

  assign dx = DiffW'(point_x_i) - DiffW'(neighbor_x_i);
  assign dy = DiffW'(point_y_i) - DiffW'(neighbor_y_i);
  assign dz = DiffW'(point_z_i) - DiffW'(neighbor_z_i);
  assign ax = dx[DiffW-1] ? MagW'(-dx) : MagW'(dx);
  assign ay = dy[DiffW-1] ? MagW'(-dy) : MagW'(dy);
  assign az = dz[DiffW-1] ? MagW'(-dz) : MagW'(dz);

  // mask unused dimensions
  always_comb begin
    s1_d       = '0;
    s1_d.idx   = point_index_i;
    s1_d.aff   = affinity_i;
    s1_d.last  = last_in_row_i;
    if (Dims >= 1) begin
      s1_d.mag_x = ax;
      s1_d.neg[0] = dx[DiffW-1];
    end
    if (Dims >= 2) begin
      s1_d.mag_y = ay;
      s1_d.neg[1] = dy[DiffW-1];
    end
    if (Dims >= 3) begin
      s1_d.mag_z = az;
      s1_d.neg[2] = dz[DiffW-1];
    end
  end

  // pipeline holds while queue space is short; count queued items
  assign push   = s2_valid_q && (cnt_q < 2'(QueueDepth) || q_pop_i);
  assign s2_adv = !s2_valid_q || push;
  assign s1_adv = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign acc_in = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= acc_in;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) s1_q <= s1_d;
    if (s2_adv) begin
      s2_q   <= s1_q;
      sq_x_q <= s1_q.mag_x * s1_q.mag_x;
      sq_y_q <= s1_q.mag_y * s1_q.mag_y;
      sq_z_q <= s1_q.mag_z * s1_q.mag_z;
    end
  end

  // attach the summed distance to the request
  always_comb begin
    push_e    = s2_q;
    push_e.dq = DqW'(sq_x_q) + DqW'(sq_y_q) + DqW'(sq_z_q);
  end

  // push into queue
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assign q_valid_o = cnt_q != '0;
  assign q_head_o  = mem_q[rp_q];

  `ASSERT_NEVER(a_q_over, clk_i, rst_ni, cnt_q > 2'(QueueDepth), "queue overflow")
  `ASSERT_NEVER(a_q_under, clk_i, rst_ni, q_pop_i && cnt_q == '0, "pop of empty queue")
  `ASSERT_IMPL(a_cnt, clk_i, rst_ni, (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1, "count did not follow push")
endmodule

FILE: sv/tefa_div.sv
// Restoring divider: floor(aff * 2^32 / (2^32 + dq)), one quotient bit a cycle.
// Depends on tefa_pkg.
module tefa_div import tefa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AffW-1:0] aff_i,
  input  logic [DqW-1:0]  dq_i,
  output logic            done_o,
  output logic [AffW-1:0] quo_o
);
  localparam int unsigned DenW = DqW + 1;
  logic [DivW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DenW:0]    rem_q, rem_sh;
  logic [6:0]       cnt_q;
  logic             busy_q;

  assign rem_sh = {rem_q[DenW-1:0], num_q[DivW-1]};

  // shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'(DivW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {aff_i, 32'd0};
      den_q <= DenW'({1'b1, 32'd0}) + DenW'(dq_i);
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        num_q <= {num_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign done_o = busy_q && cnt_q == 7'd1;
  // quotient fits: it never exceeds the affinity
  always_comb begin
    quo_o = {num_q[AffW-2:0], rem_sh >= {1'b0, den_q}};
  end
endmodule

FILE: sv/tefa_back.sv
// Back end: weight by division, scaled terms, saturating accumulate, result.
// Depends on tefa_pkg and tefa_div.
`include "assert_macros.svh"
module tefa_back import tefa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  output logic                     q_pop_o,
  input  edge_t                    q_head_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IdxW-1:0]          row_point_o,
  output logic signed [ForceW-1:0] force_x_o,
  output logic signed [ForceW-1:0] force_y_o,
  output logic signed [ForceW-1:0] force_z_o
);
  localparam logic signed [ForceW:0] SumMax = {2'b00, {(ForceW-1){1'b1}}};
  localparam logic signed [ForceW:0] SumMin = {2'b11, {(ForceW-1){1'b0}}};
  localparam int unsigned ProdW = AffW + MagW;

  back_state_e state_q, state_d;
  edge_t       cur_q;
  logic        div_done;
  logic [AffW-1:0] quo, w_q;
  logic [ProdW-1:0] px_q, py_q, pz_q;
  logic signed [ForceW-1:0] sx_q, sy_q, sz_q;
  logic        busy_out_q;
  logic        start_div, ld;

  tefa_div u_div (
    .clk_i, .rst_ni, .start_i(start_div), .aff_i(q_head_i.aff), .dq_i(q_head_i.dq),
    .done_o(div_done), .quo_o(quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = cur_q.last ? ST_OUT : ST_IDLE;
      ST_OUT:  if (!busy_out_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    start_div = state_q == ST_IDLE && q_valid_i;
    q_pop_o   = start_div;
    ld        = state_q == ST_OUT && (!busy_out_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (start_div) cur_q <= q_head_i;
    if (div_done)  w_q   <= quo;
    if (state_q == ST_MUL) begin
      px_q <= w_q * cur_q.mag_x;
      py_q <= w_q * cur_q.mag_y;
      pz_q <= w_q * cur_q.mag_z;
    end
  end

  function automatic logic signed [ForceW-1:0] sat_add(
    input logic signed [ForceW-1:0] acc, input logic [ProdW-1:0] p, input logic neg);
    logic signed [ForceW:0] t, s;
    t = (ForceW+1)'(p >> 16);
    if (neg) t = -t;
    s = {acc[ForceW-1], acc} + t;
    if (s > SumMax) s = SumMax;
    else if (s < SumMin) s = SumMin;
    return s[ForceW-1:0];
  endfunction

  // accumulate, clear after the row is handed to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      sz_q <= '0;
    end else if (state_q == ST_ACC) begin
      sx_q <= sat_add(sx_q, px_q, cur_q.neg[0]);
      sy_q <= sat_add(sy_q, py_q, cur_q.neg[1]);
      sz_q <= sat_add(sz_q, pz_q, cur_q.neg[2]);
    end else if (ld) begin
      sx_q <= '0;
      sy_q <= '0;
      sz_q <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_out_q <= 1'b0;
    else if (ld) busy_out_q <= 1'b1;
    else if (!out_stall_i) busy_out_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      row_point_o <= cur_q.idx;
      force_x_o   <= sx_q;
      force_y_o   <= sy_q;
      force_z_o   <= sz_q;
    end
  end

  assign out_valid_o = busy_out_q;

  `ASSERT_IMPL(a_div_done, clk_i, rst_ni, div_done |-> state_q == ST_DIV, "divider finished outside divide state")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped while stalled")
  `ASSERT_NEVER(a_pop, clk_i, rst_ni, q_pop_o && !q_valid_i, "pop without entry")
endmodule

FILE: sv/tsne_edge_force_accumulator_core.sv
// t-SNE attractive edge force accumulator, top level.
// Each accepted input item is one sparse affinity edge of a row point.
// Channels: in_valid_i/in_stall_o with the edge fields, out_valid_o/out_stall_i
// with row_point_o and force_x_o/y_o/z_o. An item moves when valid is high
// and stall is low at a rising edge of clk_i.
// The front end forms differences and the squared distance in two stages
// and puts the edge into a two-entry queue. The back end divides
// affinity*2^32 by (2^32 + D) with a one-bit-per-cycle divider, then
// multiplies and accumulates; an edge is popped, divided, multiplied and
// accumulated before the queue is popped again. An edge marked last in row
// loads the row force into the output register from the output state, once
// that register is free; rows emit no result until that edge. The output
// register holds while out_stall_i is high; a back end with another row
// result then waits and the queue fills, then in_stall_o rises.
// Reset (rst_ni low, asynchronous) clears the queue, the sequencer, the
// output valid and the force accumulators.
module tsne_edge_force_accumulator_core import tefa_pkg::*; #(
  parameter int unsigned Dims = DimsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IdxW-1:0]          point_index_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic signed [CoordW-1:0] neighbor_x_i,
  input  logic signed [CoordW-1:0] neighbor_y_i,
  input  logic signed [CoordW-1:0] neighbor_z_i,
  input  logic [AffW-1:0]          affinity_i,
  input  logic                     last_in_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IdxW-1:0]          row_point_o,
  output logic signed [ForceW-1:0] force_x_o,
  output logic signed [ForceW-1:0] force_y_o,
  output logic signed [ForceW-1:0] force_z_o
);
  logic  q_valid, q_pop;
  edge_t q_head;

  tefa_front #(.Dims(Dims)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .point_index_i,
    .point_x_i, .point_y_i, .point_z_i, .neighbor_x_i, .neighbor_y_i,
    .neighbor_z_i, .affinity_i, .last_in_row_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_head_o(q_head)
  );

  tefa_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_head_i(q_head),
    .out_valid_o, .out_stall_i, .row_point_o, .force_x_o, .force_y_o, .force_z_o
  );
endmodule
